@@ sv/sample_moment_statistics_unit_assert.svh @@
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef SAMPLE_MOMENT_STATISTICS_UNIT_ASSERT_SVH
`define SAMPLE_MOMENT_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication
`define SMSU_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMSU_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/smsu_pkg.sv @@
`default_nettype none
package smsu_pkg;

  localparam int DEFAULT_MAX_SAMPLES = 1024;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  // wide enough for the fourth-power sums at the largest buffer and sample size
  localparam int WIDE_W = 256;

  localparam logic [31:0] THREE_Q16 = 32'd196608;

  typedef logic [WIDE_W-1:0] wide_t;

  function automatic logic [63:0] sat_w(input wide_t v, input logic [63:0] lim);
    logic [63:0] r;
    if (v > WIDE_W'(lim)) r = lim;
    else r = v[63:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/smsu_if.sv @@
`default_nettype none
interface smsu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface smsu_out_if;
  logic        valid;
  logic        ready;
  logic        stats_ok;
  logic        shape_defined;
  logic        samples_dropped;
  logic [31:0] mean_value;
  logic [31:0] mean_abs_dev;
  logic [31:0] std_dev;
  logic [47:0] variance_value;
  logic [31:0] skewness;
  logic [31:0] excess_kurtosis;

  modport source (output valid, output stats_ok, output shape_defined,
                  output samples_dropped, output mean_value, output mean_abs_dev,
                  output std_dev, output variance_value, output skewness,
                  output excess_kurtosis, input ready);
  modport sink   (input valid, input stats_ok, input shape_defined,
                  input samples_dropped, input mean_value, input mean_abs_dev,
                  input std_dev, input variance_value, input skewness,
                  input excess_kurtosis, output ready);
endinterface
`default_nettype wire

@@ sv/smsu_mul.sv @@
`default_nettype none
module smsu_mul
  import smsu_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  input  wide_t a,
  input  wide_t b,
  output logic  busy,
  output logic  done,
  output wide_t prod
);

  wide_t a_r, b_r, p_r;
  logic  busy_r, done_r;

  // shift-add, one multiplier bit per cycle, ends when the multiplier runs out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r && b_r != '0) begin
      if (b_r[0]) p_r <= p_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = p_r;

endmodule
`default_nettype wire

@@ sv/smsu_div.sv @@
`default_nettype none
module smsu_div
  import smsu_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  input  wide_t num,
  input  wide_t den,
  output logic  busy,
  output logic  done,
  output wide_t quo,
  output logic  rem_nz
);

  localparam int CW = $clog2(WIDE_W) + 1;

  logic [CW-1:0]   cnt_r;
  logic            done_r;
  wide_t           num_r, den_r, q_r;
  logic [WIDE_W:0] rem_r, rem_sh;
  logic            fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r[WIDE_W-1:0], num_r[WIDE_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(WIDE_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      num_r <= num_r << 1;
      if (fits) begin
        rem_r <= rem_sh - {1'b0, den_r};
        q_r   <= {q_r[WIDE_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[WIDE_W-2:0], 1'b0};
      end
    end
  end

  assign busy   = cnt_r != '0;
  assign done   = done_r;
  assign quo    = q_r;
  assign rem_nz = |rem_r;

endmodule
`default_nettype wire

@@ sv/sample_moment_statistics_unit.sv @@
// Moment statistics over a set of signed samples.
// in_ch carries one sample per beat plus last_sample; samples are written to an
// on-chip buffer, one per cycle, while the block is loading. The beat marked last
// closes the set and in_ch.ready drops until the result has been formed.
// out_ch carries one result beat per set: flags, mean, mean absolute deviation,
// variance, standard deviation, skewness and excess kurtosis.
// Time after the last beat is set by the shared shift-add multiplier and the
// bit-serial divider: five divides, plus per sample the square, cube and fourth
// power of the deviation (shift-add steps), plus a bit-serial square root and the
// wide multiplies of n and the variance. Sets of fewer than two samples skip the
// arithmetic and pass through the done state into the output register once free.
// Loading runs at one sample per cycle; a new set loads while the previous result
// still waits in the output register. If the receiver stalls, the finished result
// waits until the output register is free, holding off the next set. Samples beyond
// the buffer depth are dropped and flagged. Reset empties the set; the buffer needs
// no clear.
`default_nettype none
module sample_moment_statistics_unit
  import smsu_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input wire          clk,
  input wire          rst_n,
  smsu_in_if.sink     in_ch,
  smsu_out_if.source  out_ch
);

`include "sample_moment_statistics_unit_assert.svh"

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int SUM_W = SAMPLE_BITS + CNT_W + 1;
  localparam int DEV_W = SUM_W;

  localparam logic [4:0] ST_LOAD = 5'd0;
  localparam logic [4:0] ST_MEAN = 5'd1;
  localparam logic [4:0] ST_RD   = 5'd2;
  localparam logic [4:0] ST_DEV  = 5'd3;
  localparam logic [4:0] ST_SQ   = 5'd4;
  localparam logic [4:0] ST_CU   = 5'd5;
  localparam logic [4:0] ST_QU   = 5'd6;
  localparam logic [4:0] ST_N2   = 5'd7;
  localparam logic [4:0] ST_N4   = 5'd8;
  localparam logic [4:0] ST_D1   = 5'd9;
  localparam logic [4:0] ST_MAD  = 5'd10;
  localparam logic [4:0] ST_VARI = 5'd11;
  localparam logic [4:0] ST_SQRT = 5'd12;
  localparam logic [4:0] ST_SK1  = 5'd13;
  localparam logic [4:0] ST_SK2  = 5'd14;
  localparam logic [4:0] ST_SK3  = 5'd15;
  localparam logic [4:0] ST_KU1  = 5'd16;
  localparam logic [4:0] ST_KU2  = 5'd17;
  localparam logic [4:0] ST_KU3  = 5'd18;
  localparam logic [4:0] ST_KU4  = 5'd19;
  localparam logic [4:0] ST_DONE = 5'd20;

  logic [4:0]              state_r;
  logic [CNT_W-1:0]        cnt_r, idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    ovf_r;

  logic [SAMPLE_BITS-1:0]  mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_r;

  // arithmetic units
  logic  mul_start_r, mul_busy, mul_done;
  wide_t mul_a_r, mul_b_r, mul_p;
  logic  div_start_r, div_busy, div_done, div_rnz;
  wide_t div_n_r, div_d_r, div_q;

  // pass accumulators
  logic [DEV_W-1:0] m_r;
  logic             neg_r;
  logic [63:0]      absum_r;
  wide_t            sq_r, m2_r, m3p_r, m3n_r, m4_r, n2_r, n4_r, vden_r;

  // square root
  logic [63:0] sq_v_r, sq_res_r, sq_one_r, sq_sum;
  logic        sq_ge;

  // result being formed
  logic        res_ok_r, res_shape_r, res_drop_r;
  logic [31:0] mean_r, mad_r, sd_r, skew_r, kurt_r;
  logic [47:0] vari_r;

  // output register
  logic        out_valid_r, o_ok_r, o_shape_r, o_drop_r;
  logic [31:0] o_mean_r, o_mad_r, o_sd_r, o_skew_r, o_kurt_r;
  logic [47:0] o_vari_r;

  // input side
  logic [31:0]                   in_ext;
  logic signed [SAMPLE_BITS-1:0] in_x;
  logic                          in_fire, room, ovf_aft;
  logic [CNT_W-1:0]              cnt_aft;
  logic signed [SUM_W-1:0]       sum_aft;
  logic [SUM_W-1:0]              mag_s;

  assign in_ext  = {16'b0, in_ch.sample};
  assign in_x    = $signed(in_ext[SAMPLE_BITS-1:0]);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign room    = cnt_r < CNT_W'(MAX_SAMPLES);
  assign cnt_aft = room ? cnt_r + 1'b1 : cnt_r;
  assign sum_aft = room ? sum_r + SUM_W'(in_x) : sum_r;
  assign ovf_aft = ovf_r | !room;
  assign mag_s   = sum_aft[SUM_W-1] ? SUM_W'(-sum_aft) : SUM_W'(sum_aft);

  assign in_ch.ready = state_r == ST_LOAD;

  // deviation scaled by n: d = n*x - S
  logic signed [DEV_W-1:0] nx, dev;
  logic [DEV_W-1:0]        dev_mag;
  assign nx      = DEV_W'($signed({1'b0, cnt_r})) * DEV_W'(rd_r);
  assign dev     = nx - sum_r;
  assign dev_mag = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);

  // final scaling and saturation
  logic [31:0]        mean_val, skew_val, kurt_val;
  logic [47:0]        vari_val;
  logic               m3_ge;
  wide_t              m3_diff;
  logic [40:0]        kq;
  logic signed [42:0] kv0, kv1;

  assign mean_val = sum_r[SUM_W-1] ? 32'(-sat_w(div_q, 64'h8000_0000))
                                   : 32'(sat_w(div_q, 64'h7FFF_FFFF));
  assign vari_val = 48'(sat_w(div_q, 64'hFFFF_FFFF_FFFF));
  assign m3_ge    = m3p_r >= m3n_r;
  assign m3_diff  = m3_ge ? m3p_r - m3n_r : m3n_r - m3p_r;
  assign skew_val = m3_ge ? 32'(sat_w(div_q, 64'h7FFF_FFFF))
                          : 32'(-sat_w(div_q, 64'h8000_0000));
  assign kq       = 41'(sat_w(div_q, 64'h100_0000_0000));
  assign kv0      = $signed({2'b0, kq}) - $signed({11'b0, THREE_Q16});
  // truncate toward zero when the shifted quotient goes negative
  assign kv1      = (kv0 < 0 && div_rnz) ? kv0 + 43'sd1 : kv0;
  assign kurt_val = (kv1 > 43'sd2147483647) ? 32'h7FFF_FFFF : kv1[31:0];

  assign sq_sum = sq_res_r + sq_one_r;
  assign sq_ge  = sq_v_r >= sq_sum;

  smsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_p)
  );

  smsu_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start_r),
    .num    (div_n_r),
    .den    (div_d_r),
    .busy   (div_busy),
    .done   (div_done),
    .quo    (div_q),
    .rem_nz (div_rnz)
  );

  // sample buffer
  always_ff @(posedge clk) begin
    if (in_fire && room) mem[cnt_r[AW-1:0]] <= in_ext[SAMPLE_BITS-1:0];
    rd_r <= $signed(mem[idx_r[AW-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      // in ST_DONE the output register is refilled below instead
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            cnt_r <= cnt_aft;
            sum_r <= sum_aft;
            ovf_r <= ovf_aft;
            if (in_ch.last_sample) begin
              res_ok_r    <= cnt_aft >= CNT_W'(2);
              res_shape_r <= 1'b0;
              res_drop_r  <= ovf_aft;
              mean_r      <= '0;
              mad_r       <= '0;
              sd_r        <= '0;
              vari_r      <= '0;
              skew_r      <= '0;
              kurt_r      <= '0;
              absum_r     <= '0;
              m2_r        <= '0;
              m3p_r       <= '0;
              m3n_r       <= '0;
              m4_r        <= '0;
              if (cnt_aft >= CNT_W'(2)) begin
                div_n_r     <= WIDE_W'(mag_s) << 16;
                div_d_r     <= WIDE_W'(cnt_aft);
                div_start_r <= 1'b1;
                state_r     <= ST_MEAN;
              end else begin
                state_r <= ST_DONE;
              end
            end
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            mean_r  <= mean_val;
            idx_r   <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_DEV;
        ST_DEV: begin
          m_r         <= dev_mag;
          neg_r       <= dev[DEV_W-1];
          absum_r     <= absum_r + 64'(dev_mag);
          mul_a_r     <= WIDE_W'(dev_mag);
          mul_b_r     <= WIDE_W'(dev_mag);
          mul_start_r <= 1'b1;
          state_r     <= ST_SQ;
        end
        ST_SQ: begin
          if (mul_done) begin
            sq_r        <= mul_p;
            m2_r        <= m2_r + mul_p;
            mul_a_r     <= mul_p;
            mul_b_r     <= WIDE_W'(m_r);
            mul_start_r <= 1'b1;
            state_r     <= ST_CU;
          end
        end
        ST_CU: begin
          if (mul_done) begin
            if (neg_r) m3n_r <= m3n_r + mul_p;
            else       m3p_r <= m3p_r + mul_p;
            mul_a_r     <= sq_r;
            mul_b_r     <= sq_r;
            mul_start_r <= 1'b1;
            state_r     <= ST_QU;
          end
        end
        ST_QU: begin
          if (mul_done) begin
            m4_r  <= m4_r + mul_p;
            idx_r <= idx_r + 1'b1;
            if (idx_r + 1'b1 == cnt_r) begin
              mul_a_r     <= WIDE_W'(cnt_r);
              mul_b_r     <= WIDE_W'(cnt_r);
              mul_start_r <= 1'b1;
              state_r     <= ST_N2;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_N2: begin
          if (mul_done) begin
            n2_r        <= mul_p;
            mul_a_r     <= mul_p;
            mul_b_r     <= mul_p;
            mul_start_r <= 1'b1;
            state_r     <= ST_N4;
          end
        end
        ST_N4: begin
          if (mul_done) begin
            n4_r        <= mul_p;
            mul_a_r     <= n2_r;
            mul_b_r     <= WIDE_W'(cnt_r - 1'b1);
            mul_start_r <= 1'b1;
            state_r     <= ST_D1;
          end
        end
        ST_D1: begin
          if (mul_done) begin
            vden_r      <= mul_p;
            div_n_r     <= WIDE_W'(absum_r) << 16;
            div_d_r     <= n2_r;
            div_start_r <= 1'b1;
            state_r     <= ST_MAD;
          end
        end
        ST_MAD: begin
          if (div_done) begin
            mad_r       <= 32'(sat_w(div_q, 64'hFFFF_FFFF));
            div_n_r     <= m2_r << 16;
            div_d_r     <= vden_r;
            div_start_r <= 1'b1;
            state_r     <= ST_VARI;
          end
        end
        ST_VARI: begin
          if (div_done) begin
            vari_r   <= vari_val;
            sq_v_r   <= {vari_val, 16'b0};
            sq_res_r <= '0;
            sq_one_r <= 64'h4000_0000_0000_0000;
            state_r  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_one_r != '0) begin
            if (sq_ge) begin
              sq_v_r   <= sq_v_r - sq_sum;
              sq_res_r <= (sq_res_r >> 1) + sq_one_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_one_r <= sq_one_r >> 2;
          end else begin
            sd_r <= sq_res_r[31:0];
            if (vari_r == '0) begin
              state_r <= ST_DONE;
            end else begin
              res_shape_r <= 1'b1;
              mul_a_r     <= n4_r;
              mul_b_r     <= WIDE_W'(vari_r);
              mul_start_r <= 1'b1;
              state_r     <= ST_SK1;
            end
          end
        end
        ST_SK1: begin
          if (mul_done) begin
            mul_a_r     <= mul_p;
            mul_b_r     <= WIDE_W'(sd_r);
            mul_start_r <= 1'b1;
            state_r     <= ST_SK2;
          end
        end
        ST_SK2: begin
          if (mul_done) begin
            div_n_r     <= m3_diff << 48;
            div_d_r     <= mul_p;
            div_start_r <= 1'b1;
            state_r     <= ST_SK3;
          end
        end
        ST_SK3: begin
          if (div_done) begin
            skew_r      <= skew_val;
            mul_a_r     <= n4_r;
            mul_b_r     <= WIDE_W'(cnt_r);
            mul_start_r <= 1'b1;
            state_r     <= ST_KU1;
          end
        end
        ST_KU1, ST_KU2: begin
          if (mul_done) begin
            mul_a_r     <= mul_p;
            mul_b_r     <= WIDE_W'(vari_r);
            mul_start_r <= 1'b1;
            state_r     <= (state_r == ST_KU1) ? ST_KU2 : ST_KU3;
          end
        end
        ST_KU3: begin
          if (mul_done) begin
            div_n_r     <= m4_r << 48;
            div_d_r     <= mul_p;
            div_start_r <= 1'b1;
            state_r     <= ST_KU4;
          end
        end
        ST_KU4: begin
          if (div_done) begin
            kurt_r  <= kurt_val;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_ok_r      <= res_ok_r;
            o_shape_r   <= res_shape_r;
            o_drop_r    <= res_drop_r;
            o_mean_r    <= mean_r;
            o_mad_r     <= mad_r;
            o_sd_r      <= sd_r;
            o_vari_r    <= vari_r;
            o_skew_r    <= skew_r;
            o_kurt_r    <= kurt_r;
            cnt_r       <= '0;
            sum_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.stats_ok        = o_ok_r;
  assign out_ch.shape_defined   = o_shape_r;
  assign out_ch.samples_dropped = o_drop_r;
  assign out_ch.mean_value      = o_mean_r;
  assign out_ch.mean_abs_dev    = o_mad_r;
  assign out_ch.std_dev         = o_sd_r;
  assign out_ch.variance_value  = o_vari_r;
  assign out_ch.skewness        = o_skew_r;
  assign out_ch.excess_kurtosis = o_kurt_r;

  `SMSU_CHK(a_cnt_range, 1'b1, cnt_r <= CNT_W'(MAX_SAMPLES), "sample count past depth")
  `SMSU_CHK_NEXT(a_done_waits, state_r == ST_DONE && out_valid_r && !out_ch.ready,
                 state_r == ST_DONE, "result left while output register full")
  `SMSU_CHK(a_mul_idle, mul_start_r, !mul_busy, "multiplier started while busy")
  `SMSU_CHK(a_div_idle, div_start_r, !div_busy, "divider started while busy")
  `SMSU_CHK(a_shape_ok, out_valid_r && o_shape_r, o_ok_r, "shape flag without stats")

endmodule
`default_nettype wire
